@@ hdl/scdb_pkg.sv @@
// scdb_pkg: shared types and constants for the scsi cdb command decoder
// used by scdb_ctrl, scdb_datapath and scsi_cdb_command_decoder
`timescale 1ns / 1ps

package scdb_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int IDX_W       = $clog2(STORE_DEPTH + 1);

  localparam logic [31:0] TOTAL_BLOCKS_RST = 32'd65536;
  localparam logic [31:0] CAP_RESERVED     = 32'd256;
  localparam logic [31:0] SHORT_LEN_ZERO   = 32'd256;

  // opcodes
  localparam logic [7:0] OP_TEST_READY = 8'h00;
  localparam logic [7:0] OP_READ6      = 8'h08;
  localparam logic [7:0] OP_WRITE6     = 8'h0A;
  localparam logic [7:0] OP_INQUIRY    = 8'h12;
  localparam logic [7:0] OP_MODE_SENSE = 8'h1A;
  localparam logic [7:0] OP_READ_CAP   = 8'h25;
  localparam logic [7:0] OP_READ10     = 8'h28;
  localparam logic [7:0] OP_WRITE10    = 8'h2A;
  localparam logic [7:0] OP_VERIFY     = 8'h2F;
  localparam logic [7:0] OP_READ16     = 8'h88;
  localparam logic [7:0] OP_WRITE16    = 8'h8A;
  localparam logic [7:0] OP_REPORT_LUN = 8'hA0;
  localparam logic [7:0] OP_READ12     = 8'hA8;
  localparam logic [7:0] OP_WRITE12    = 8'hAA;

  // mode sense
  localparam logic [1:0] PC_CHANGEABLE = 2'd1;
  localparam logic [5:0] PAGE_ALL      = 6'h3F;
  localparam logic [5:0] PAGE_FORMAT   = 6'h03;
  localparam logic [5:0] PAGE_DISCON   = 6'h02;
  localparam logic [7:0] MODE_HDR_LEN  = 8'd4;
  localparam logic [7:0] MODE_BD_LEN   = 8'd8;
  localparam logic [7:0] MODE_FMT_LEN  = 8'd24;
  localparam logic [7:0] MODE_DISC_LEN = 8'd16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CL_NONE     = 3'd0,
    CL_READ     = 3'd1,
    CL_WRITE    = 3'd2,
    CL_CAPACITY = 3'd3,
    CL_INQUIRY  = 3'd4,
    CL_MODE     = 3'd5,
    CL_NOP      = 3'd6
  } class_e;

  typedef enum logic [1:0] {
    FK_EXEC   = 2'd0,
    FK_MGMT   = 2'd1,
    FK_REJECT = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    MUL_LO  = 2'd0,
    MUL_HI  = 2'd1,
    MUL_CNT = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     store_wr;
    logic     capture;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     load_out;
  } scdb_cmd_t;

endpackage

@@ hdl/scsi_cdb_command_decoder.sv @@
// scsi_cdb_command_decoder: top level of the scsi cdb command decoder
// depends on scdb_pkg, scdb_ctrl and scdb_datapath
//
//   channel  direction  handshake              payload
//   in       to block   in_valid_i/in_stall_o  cdb_byte, last_byte, lun, target_id,
//                                              path_id, prior_status, function_kind
//   out      from block out_valid_o/out_stall_i status .. mode_length
//   cfg      to block   cfg_valid_i/cfg_ready_o cfg_total_blocks_i
//
// a byte without the last mark is taken one item per cycle while the input is not stalled
// a last byte stalls the input while the block-size multiplier forms the offset halves
// and the length in turn, then the result moves to the output register
// a pending result does not block new bytes; a second result waits in the push step
// reset clears the byte store and counter at once and loads total_blocks with 65536
`timescale 1ns / 1ps

module scsi_cdb_command_decoder import scdb_pkg::*; #(
  parameter int CDB_BYTES   = 16,
  parameter int BLOCK_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  cdb_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  lun_i,
  input  logic [7:0]  target_id_i,
  input  logic [7:0]  path_id_i,
  input  logic [7:0]  prior_status_i,
  input  logic [1:0]  function_kind_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  command_class_o,
  output logic [63:0] start_block_o,
  output logic [31:0] block_count_o,
  output logic [63:0] byte_offset_o,
  output logic [40:0] byte_length_o,
  output logic [31:0] capacity_last_block_o,
  output logic [5:0]  mode_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_total_blocks_i
);

  scdb_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  scdb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  scdb_datapath #(
    .CDB_BYTES   (CDB_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_total_blocks_i    (cfg_total_blocks_i),
    .cdb_byte_i            (cdb_byte_i),
    .lun_i                 (lun_i),
    .target_id_i           (target_id_i),
    .path_id_i             (path_id_i),
    .prior_status_i        (prior_status_i),
    .function_kind_i       (function_kind_i),
    .status_o              (status_o),
    .command_class_o       (command_class_o),
    .start_block_o         (start_block_o),
    .block_count_o         (block_count_o),
    .byte_offset_o         (byte_offset_o),
    .byte_length_o         (byte_length_o),
    .capacity_last_block_o (capacity_last_block_o),
    .mode_length_o         (mode_length_o)
  );

  // a last byte always holds off the next item
  a_capture_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> in_stall_o)
    else $error("input not stalled after last byte");

  // results are only loaded while a command is in flight
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> in_stall_o)
    else $error("result loaded with no command in flight");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o && !in_stall_o)
    else $error("loaded result not presented");

  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_en |-> in_stall_o && !cmd.store_wr)
    else $error("multiply step while input open");

endmodule

@@ hdl/scdb_ctrl.sv @@
// scdb_ctrl: sequencer for byte collection, geometry multiplies and result handoff
// depends on scdb_pkg
`timescale 1ns / 1ps

module scdb_ctrl import scdb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      last_byte_i,
  input  logic      out_stall_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output scdb_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_CNT,
    S_PUSH
  } state_e;

  state_e state_q;
  logic   stall_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_LO;
    cmd_o.store_wr = in_valid_i && !stall_q;
    cmd_o.capture  = in_valid_i && !stall_q && last_byte_i;
    case (state_q)
      S_MUL_LO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LO;
      end
      S_MUL_HI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HI;
      end
      S_MUL_CNT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_CNT;
      end
      S_PUSH: begin
        // output register free or being emptied this cycle
        cmd_o.load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
        cmd_o.mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stall_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= S_MUL_LO;
            stall_q <= 1'b1;
          end
        end
        S_MUL_LO:  state_q <= S_MUL_HI;
        S_MUL_HI:  state_q <= S_MUL_CNT;
        S_MUL_CNT: state_q <= S_PUSH;
        S_PUSH: begin
          if (cmd_o.load_out) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o  = stall_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/scdb_datapath.sv @@
// scdb_datapath: byte store, cdb decode, shared block-size multiplier, result registers
// depends on scdb_pkg; driven by scdb_ctrl commands
`timescale 1ns / 1ps

module scdb_datapath import scdb_pkg::*; #(
  parameter int CDB_BYTES   = 16,
  parameter int BLOCK_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  scdb_cmd_t   cmd_i,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_total_blocks_i,
  input  logic [7:0]  cdb_byte_i,
  input  logic [7:0]  lun_i,
  input  logic [7:0]  target_id_i,
  input  logic [7:0]  path_id_i,
  input  logic [7:0]  prior_status_i,
  input  logic [1:0]  function_kind_i,
  output logic [1:0]  status_o,
  output logic [2:0]  command_class_o,
  output logic [63:0] start_block_o,
  output logic [31:0] block_count_o,
  output logic [63:0] byte_offset_o,
  output logic [40:0] byte_length_o,
  output logic [31:0] capacity_last_block_o,
  output logic [5:0]  mode_length_o
);

  localparam int BW = $clog2(BLOCK_BYTES + 1);
  localparam logic [BW-1:0]    BLK    = BW'(BLOCK_BYTES);
  localparam logic [IDX_W-1:0] CDB_N  = IDX_W'(CDB_BYTES);

  logic [7:0]       store_q [STORE_DEPTH];
  logic [IDX_W-1:0] idx_q;
  logic [31:0]      total_q;
  logic             wr_ok;
  logic [7:0]       view [STORE_DEPTH];

  // decoded command
  status_e     dec_st;
  class_e      dec_cls;
  logic [63:0] dec_start;
  logic [31:0] dec_count;
  logic [31:0] dec_cap;
  logic [5:0]  dec_mlen;
  logic [7:0]  ml;
  logic [7:0]  alloc;

  // held command while the multiplies run
  status_e     st_q;
  class_e      cls_q;
  logic [63:0] start_q;
  logic [31:0] count_q;
  logic [31:0] cap_q;
  logic [5:0]  mlen_q;
  logic [63:0] off_q;
  logic [40:0] len_q;

  // result register
  logic [1:0]  res_status_q;
  logic [2:0]  res_class_q;
  logic [63:0] res_start_q;
  logic [31:0] res_count_q;
  logic [63:0] res_offset_q;
  logic [40:0] res_length_q;
  logic [31:0] res_cap_q;
  logic [5:0]  res_mlen_q;

  logic [31:0]      mul_a;
  logic [32+BW-1:0] prod;

  assign wr_ok = cmd_i.store_wr && (idx_q < CDB_N);

  // store contents with the byte of this cycle merged in
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      view[i] = store_q[i];
      if (wr_ok && (idx_q[STORE_AW-1:0] == STORE_AW'(i))) begin
        view[i] = cdb_byte_i;
      end
    end
  end

  always_comb begin
    alloc = view[4];
    ml    = MODE_HDR_LEN;
    if (view[2][7:6] == PC_CHANGEABLE) begin
      ml = '0;
    end else begin
      if (!view[1][3] && (alloc >= ml + MODE_BD_LEN)) begin
        ml = ml + MODE_BD_LEN;
      end
      if ((alloc >= ml + MODE_FMT_LEN) &&
          ((view[2][5:0] == PAGE_ALL) || (view[2][5:0] == PAGE_FORMAT))) begin
        ml = ml + MODE_FMT_LEN;
      end
      if ((alloc >= ml + MODE_DISC_LEN) &&
          ((view[2][5:0] == PAGE_ALL) || (view[2][5:0] == PAGE_DISCON))) begin
        ml = ml + MODE_DISC_LEN;
      end
    end
  end

  always_comb begin
    dec_st    = ST_OK;
    dec_cls   = CL_NONE;
    dec_start = '0;
    dec_count = '0;
    dec_cap   = '0;
    dec_mlen  = '0;
    if ((lun_i != '0) || (target_id_i != '0) || (path_id_i != '0) ||
        (prior_status_i != '0)) begin
      dec_st = ST_TIMEOUT;
    end else if (function_kind_i == FK_REJECT) begin
      dec_st = ST_INVALID;
    end else if (function_kind_i == FK_EXEC) begin
      case (view[0])
        OP_READ6, OP_WRITE6: begin
          dec_cls   = (view[0] == OP_READ6) ? CL_READ : CL_WRITE;
          dec_start = {43'd0, view[1][4:0], view[2], view[3]};
          dec_count = (view[4] == '0) ? SHORT_LEN_ZERO : {24'd0, view[4]};
        end
        OP_READ10, OP_WRITE10: begin
          dec_cls   = (view[0] == OP_READ10) ? CL_READ : CL_WRITE;
          dec_start = {32'd0, view[2], view[3], view[4], view[5]};
          dec_count = {16'd0, view[7], view[8]};
        end
        OP_READ12, OP_WRITE12: begin
          dec_cls   = (view[0] == OP_READ12) ? CL_READ : CL_WRITE;
          dec_start = {32'd0, view[2], view[3], view[4], view[5]};
          dec_count = {view[6], view[7], view[8], view[9]};
        end
        OP_READ16, OP_WRITE16: begin
          dec_cls   = (view[0] == OP_READ16) ? CL_READ : CL_WRITE;
          dec_start = {view[2], view[3], view[4], view[5],
                       view[6], view[7], view[8], view[9]};
          dec_count = {view[10], view[11], view[12], view[13]};
        end
        OP_READ_CAP: begin
          dec_cls = CL_CAPACITY;
          dec_cap = total_q - CAP_RESERVED;
        end
        OP_INQUIRY: begin
          dec_cls = CL_INQUIRY;
        end
        OP_MODE_SENSE: begin
          dec_cls  = CL_MODE;
          dec_mlen = ml[5:0];
        end
        OP_TEST_READY, OP_VERIFY, OP_REPORT_LUN: begin
          dec_cls = CL_NOP;
        end
        default: begin
          dec_cls = CL_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      total_q <= TOTAL_BLOCKS_RST;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        total_q <= cfg_total_blocks_i;
      end
      if (cmd_i.capture) begin
        idx_q <= '0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
          store_q[i] <= '0;
        end
      end else if (wr_ok) begin
        store_q[idx_q[STORE_AW-1:0]] <= cdb_byte_i;
        idx_q                        <= idx_q + 1'b1;
      end
    end
  end

  // one 32 x block-size multiply per cycle: offset low half, offset high half, length
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_LO:  mul_a = start_q[31:0];
      MUL_HI:  mul_a = start_q[63:32];
      MUL_CNT: mul_a = count_q;
      default: mul_a = '0;
    endcase
  end

  assign prod = mul_a * BLK;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      st_q    <= dec_st;
      cls_q   <= dec_cls;
      start_q <= dec_start;
      count_q <= dec_count;
      cap_q   <= dec_cap;
      mlen_q  <= dec_mlen;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_LO:  off_q <= 64'(prod);
        MUL_HI:  off_q <= off_q + {prod[31:0], 32'd0};
        MUL_CNT: len_q <= prod[40:0];
        default: off_q <= off_q;
      endcase
    end
    if (cmd_i.load_out) begin
      res_status_q <= st_q;
      res_class_q  <= cls_q;
      res_start_q  <= start_q;
      res_count_q  <= count_q;
      res_offset_q <= off_q;
      res_length_q <= len_q;
      res_cap_q    <= cap_q;
      res_mlen_q   <= mlen_q;
    end
  end

  assign status_o              = res_status_q;
  assign command_class_o       = res_class_q;
  assign start_block_o         = res_start_q;
  assign block_count_o         = res_count_q;
  assign byte_offset_o         = res_offset_q;
  assign byte_length_o         = res_length_q;
  assign capacity_last_block_o = res_cap_q;
  assign mode_length_o         = res_mlen_q;

endmodule
